// ----- rtl/cme_pkg.sv -----
// Shared types, constants and tables of the cylinder mesh emitter.
package cme_pkg;

  localparam int MAX_SEGMENTS = 1024;
  localparam int SEG_W        = 11;
  localparam int IDX_W        = 13;
  localparam int CORDIC_STEPS = 28;
  localparam int OUT_W        = 176;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int DIV_W        = 60;

  typedef enum logic [3:0] {
    PH_IDLE, PH_LAT_V, PH_BCENTER, PH_BRING, PH_TCENTER, PH_TRING,
    PH_LAT_T, PH_BTRI, PH_TTRI
  } phase_t;

  typedef enum logic [1:0] {
    KIND_VERTEX, KIND_TRI, KIND_ERROR, KIND_DONE
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RB, REG_RT, REG_H, REG_N, REG_CB, REG_CT
  } reg_idx_t;

  typedef enum logic [3:0] {
    B_IDLE, B_ASTEP, B_NSCALE_DN, B_NSCALE_UP, B_SQRT, B_NDIV, B_NMUL,
    B_DISPATCH, B_PHASE, B_CORDIC, B_PROD, B_UDIV, B_EMIT
  } back_state_t;

  typedef struct packed {
    logic [30:0]      rb;
    logic [30:0]      rt;
    logic [30:0]      h;
    logic [SEG_W-1:0] n;
    logic             cb;
    logic             ct;
  } cfg_t;

  typedef struct packed {
    kind_t            kind;
    logic             last;
    logic             setup;
    phase_t           phase;
    logic [SEG_W-1:0] seg;
    logic             ring;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } desc_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:    v = 30'h20000000;
      5'd1:    v = 30'h12E4051E;
      5'd2:    v = 30'h09FB385B;
      5'd3:    v = 30'h051111D4;
      5'd4:    v = 30'h028B0D43;
      5'd5:    v = 30'h0145D7E1;
      5'd6:    v = 30'h00A2F61E;
      5'd7:    v = 30'h00517C55;
      5'd8:    v = 30'h0028BE53;
      5'd9:    v = 30'h00145F2F;
      5'd10:   v = 30'h000A2F98;
      5'd11:   v = 30'h000517CC;
      5'd12:   v = 30'h00028BE6;
      5'd13:   v = 30'h000145F3;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      5'd24:   v = 30'd41;
      5'd25:   v = 30'd20;
      5'd26:   v = 30'd10;
      5'd27:   v = 30'd5;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/cylinder_mesh_emitter.sv -----
// Top level of the cylinder and cone mesh emitter.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata[0] restart
//  m_        out  m_tvalid/m_tready    m_tdata element, m_tuser kind, m_tlast
//  cfg_      in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// Triangles, cap centers, errors and done beats skip the CORDIC and products;
// cap ring vertices run the 28-step CORDIC and the products, and lateral
// vertices add the texture-u divide.
// A valid restart adds setup first: angle-step divide, normal scaling, 32-step
// square root and reciprocal divide; only the angle-step divide when height
// and radius difference are both zero. Reset is synchronous; no clearing.
// The sequencer keeps taking beats into a 4-deep queue while the output stalls, until the queue is full.
module cylinder_mesh_emitter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [0] restart
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // x_or_a, y_or_b, z_or_c, norm_x, norm_y, norm_z, tex_u, tex_v
  output logic [cme_pkg::OUT_W-1:0]      m_tdata,
  output logic [1:0]                     m_tuser,   // kind
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cme_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cme_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  logic  q_ready;
  desc_t q_wdata;
  logic  b_valid;
  logic  b_ready;
  desc_t b_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rb <= 31'd65536;
      cfg.rt <= 31'd65536;
      cfg.h  <= 31'd65536;
      cfg.n  <= SEG_W'(16);
      cfg.cb <= 1'b1;
      cfg.ct <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RB:  cfg.rb <= cfg_data[30:0];
        REG_RT:  cfg.rt <= cfg_data[30:0];
        REG_H:   cfg.h  <= cfg_data[30:0];
        REG_N:   cfg.n  <= cfg_data[SEG_W-1:0];
        REG_CB:  cfg.cb <= cfg_data[0];
        REG_CT:  cfg.ct <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cme_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_wdata)
  );

  cme_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_valid),
    .wr_ready (q_ready),
    .wr_data  (q_wdata),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  cme_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (b_valid),
    .q_ready  (b_ready),
    .q_data   (b_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- rtl/cme_fifo.sv -----
// Four-entry descriptor queue between the sequencer and the element engine.
module cme_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  cme_pkg::desc_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output cme_pkg::desc_t rd_data
);
  import cme_pkg::*;

  desc_t       mem [4];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  logic        do_wr;
  logic        do_rd;

  assign wr_ready = count != 3'd4;
  assign rd_valid = count != 3'd0;
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 2'd1;
      if (do_rd) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, do_wr} - {2'b0, do_rd};
    end
  end

endmodule

// ----- rtl/cme_div.sv -----
// Restoring divider, one quotient bit per cycle.
module cme_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cme_pkg::DIV_W-1:0] dividend,
  input  logic [31:0]               divisor,
  output logic                      done,
  output logic [cme_pkg::DIV_W-1:0] quotient
);
  import cme_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem, quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= fits ? 32'(trial - {1'b0, dvs}) : trial[31:0];
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/cme_sqrt.sv -----
// Integer square root, two radicand bits per cycle.
module cme_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cme_pkg::DIV_W-1:0] radicand,
  output logic                      done,
  output logic [29:0]               root
);
  import cme_pkg::*;

  logic        busy;
  logic [4:0]  k;
  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign bitv  = 64'd1 << (6'd62 - {k, 1'b0});
  assign trial = r + bitv;
  assign root  = r[29:0];

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      v <= {4'b0, radicand};
      r <= '0;
    end else if (busy) begin
      if (v >= trial) begin
        v <= v - trial;
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (busy) begin
        k <= k + 5'd1;
        if (k == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/cme_cordic.sv -----
// Iterative rotation CORDIC: cosine and sine of a turn phase in Q2.30.
module cme_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        ph,
  output logic               done,
  output logic signed [31:0] cs,
  output logic signed [31:0] sn
);
  import cme_pkg::*;

  localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

  logic               busy;
  logic [4:0]         i;
  logic [1:0]         quad;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [32:0] z;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [32:0] at;
  logic signed [33:0] xc;
  logic signed [33:0] yc;
  logic signed [33:0] cs_w;
  logic signed [33:0] sn_w;

  assign dx = y >>> i;
  assign dy = x >>> i;
  assign at = $signed({3'b0, atan_turn(i)});

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quad <= ph[31:30];
      z    <= $signed({3'b0, ph[29:0]});
      x    <= CORDIC_K;
      y    <= '0;
    end else if (busy) begin
      if (!z[32]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      i    <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        i    <= '0;
      end else if (busy) begin
        i <= i + 5'd1;
        if (i == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // clamp to unit magnitude, then fold the quadrant back in
  always_comb begin
    xc = (x > ONE_Q30) ? ONE_Q30 : ((x < -ONE_Q30) ? -ONE_Q30 : x);
    yc = (y > ONE_Q30) ? ONE_Q30 : ((y < -ONE_Q30) ? -ONE_Q30 : y);
    case (quad)
      2'd0:    begin cs_w = xc;  sn_w = yc;  end
      2'd1:    begin cs_w = -yc; sn_w = xc;  end
      2'd2:    begin cs_w = -xc; sn_w = -yc; end
      default: begin cs_w = yc;  sn_w = -xc; end
    endcase
    cs = cs_w[31:0];
    sn = sn_w[31:0];
  end

endmodule

// ----- rtl/cme_front.sv -----
// Sequencer: takes restart/advance beats and queues one element descriptor each.
module cme_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,
  input  cme_pkg::cfg_t  cfg,
  output logic           q_valid,
  input  logic           q_ready,
  output cme_pkg::desc_t q_data
);
  import cme_pkg::*;

  phase_t           phase;
  logic [SEG_W-1:0] seg;
  logic             ring;
  logic [SEG_W-1:0] n;
  logic             bcap;
  logic             tcap;
  logic             rbpos;
  logic             full;
  logic [IDX_W-1:0] bci;
  logic [IDX_W-1:0] tci;

  logic             restart;
  logic             cfg_ok;
  logic             bad;
  phase_t           cur_phase;
  logic [SEG_W-1:0] cur_seg;
  logic             cur_ring;
  logic [SEG_W-1:0] cur_n;
  logic             cur_bcap;
  logic             cur_tcap;
  logic             cur_rbpos;
  logic             cur_full;
  logic [IDX_W-1:0] cur_bci;
  logic [IDX_W-1:0] cur_tci;
  phase_t           phase_next;
  logic [SEG_W-1:0] seg_next;
  logic             ring_next;
  logic [SEG_W:0]   seg_inc;
  logic             more;
  logic [IDX_W-1:0] s13;
  logic [IDX_W-1:0] rw;
  logic             accept;

  function automatic phase_t open_from(input phase_t p, input logic bc, input logic tc);
    phase_t r;
    logic   found;
    logic   skip;
    r     = PH_IDLE;
    found = 1'b0;
    for (int i = int'(PH_BCENTER); i <= int'(PH_TTRI); i++) begin
      skip = ((i == int'(PH_BCENTER) || i == int'(PH_BRING) || i == int'(PH_BTRI)) && !bc)
          || ((i == int'(PH_TCENTER) || i == int'(PH_TRING) || i == int'(PH_TTRI)) && !tc);
      if (!found && i >= int'(p) && !skip) begin
        r     = phase_t'(i[3:0]);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  assign restart  = s_tdata[0];
  assign cfg_ok   = (cfg.n >= SEG_W'(3)) && (cfg.n <= SEG_W'(MAX_SEGMENTS));
  assign bad      = restart && !cfg_ok;
  assign q_valid  = s_tvalid;
  assign s_tready = q_ready;
  assign accept   = s_tvalid && s_tready;

  // mesh state as seen by this beat: a restart latches a fresh mesh first
  always_comb begin
    if (restart) begin
      cur_phase = PH_LAT_V;
      cur_seg   = '0;
      cur_ring  = 1'b0;
      cur_n     = cfg.n;
      cur_rbpos = cfg.rb != '0;
      cur_bcap  = cfg.cb && (cfg.rb != '0);
      cur_tcap  = cfg.ct && (cfg.rt != '0);
      cur_full  = (cfg.rb != '0) && (cfg.rt != '0);
      cur_bci   = IDX_W'(({2'b0, cfg.n} + 13'd1) << 1);
      cur_tci   = cur_bci + (cur_bcap ? ({2'b0, cfg.n} + 13'd2) : '0);
    end else begin
      cur_phase = phase;
      cur_seg   = seg;
      cur_ring  = ring;
      cur_n     = n;
      cur_rbpos = rbpos;
      cur_bcap  = bcap;
      cur_tcap  = tcap;
      cur_full  = full;
      cur_bci   = bci;
      cur_tci   = tci;
    end
  end

  assign seg_inc = {1'b0, cur_seg} + 12'd1;
  assign more    = seg_inc < {1'b0, cur_n};

  // next state: advance past the element of this beat
  always_comb begin
    phase_next = cur_phase;
    seg_next   = cur_seg;
    ring_next  = cur_ring;
    unique case (cur_phase)
      PH_LAT_V: begin
        if (cur_seg < cur_n) begin
          seg_next = seg_inc[SEG_W-1:0];
        end else if (!cur_ring) begin
          ring_next = 1'b1;
          seg_next  = '0;
        end else begin
          phase_next = open_from(PH_BCENTER, cur_bcap, cur_tcap);
          seg_next   = '0;
          ring_next  = 1'b0;
        end
      end
      PH_BCENTER, PH_TCENTER: begin
        phase_next = open_from(phase_t'(cur_phase + 4'd1), cur_bcap, cur_tcap);
        seg_next   = '0;
        ring_next  = 1'b0;
      end
      PH_BRING, PH_TRING: begin
        if (cur_seg < cur_n) begin
          seg_next = seg_inc[SEG_W-1:0];
        end else begin
          phase_next = open_from(phase_t'(cur_phase + 4'd1), cur_bcap, cur_tcap);
          seg_next   = '0;
          ring_next  = 1'b0;
        end
      end
      PH_LAT_T: begin
        if (cur_full && !cur_ring) begin
          ring_next = 1'b1;
        end else begin
          ring_next = 1'b0;
          if (more) begin
            seg_next = seg_inc[SEG_W-1:0];
          end else begin
            phase_next = open_from(PH_BTRI, cur_bcap, cur_tcap);
            seg_next   = '0;
          end
        end
      end
      PH_BTRI, PH_TTRI: begin
        if (more) begin
          seg_next = seg_inc[SEG_W-1:0];
        end else begin
          phase_next = open_from(phase_t'(cur_phase + 4'd1), cur_bcap, cur_tcap);
          seg_next   = '0;
          ring_next  = 1'b0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  assign s13 = {2'b0, cur_seg};
  assign rw  = {2'b0, cur_n} + 13'd1;

  // descriptor of this beat
  always_comb begin
    q_data       = '0;
    q_data.phase = cur_phase;
    q_data.seg   = cur_seg;
    q_data.ring  = cur_ring;
    if (bad) begin
      q_data.kind = KIND_ERROR;
      q_data.last = 1'b1;
    end else if (cur_phase == PH_IDLE) begin
      q_data.kind = KIND_DONE;
    end else begin
      q_data.kind  = (cur_phase >= PH_LAT_T) ? KIND_TRI : KIND_VERTEX;
      q_data.last  = phase_next == PH_IDLE;
      q_data.setup = restart;
      case (cur_phase)
        PH_LAT_T: begin
          if (cur_full && cur_ring) begin
            q_data.a = s13 + 13'd1;
            q_data.b = rw + s13 + 13'd1;
            q_data.c = rw + s13;
          end else if (cur_rbpos) begin
            q_data.a = s13;
            q_data.b = s13 + 13'd1;
            q_data.c = rw + s13;
          end else begin
            q_data.a = s13;
            q_data.b = rw + s13;
            q_data.c = rw + s13 + 13'd1;
          end
        end
        PH_BTRI: begin
          q_data.a = cur_bci;
          q_data.b = cur_bci + 13'd2 + s13;
          q_data.c = cur_bci + 13'd1 + s13;
        end
        PH_TTRI: begin
          q_data.a = cur_tci;
          q_data.b = cur_tci + 13'd1 + s13;
          q_data.c = cur_tci + 13'd2 + s13;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      seg   <= '0;
      ring  <= 1'b0;
      n     <= '0;
      bcap  <= 1'b0;
      tcap  <= 1'b0;
      rbpos <= 1'b0;
      full  <= 1'b0;
      bci   <= '0;
      tci   <= '0;
    end else if (accept) begin
      if (bad) begin
        phase <= PH_IDLE;
        seg   <= '0;
        ring  <= 1'b0;
      end else begin
        phase <= phase_next;
        seg   <= seg_next;
        ring  <= ring_next;
        n     <= cur_n;
        bcap  <= cur_bcap;
        tcap  <= cur_tcap;
        rbpos <= cur_rbpos;
        full  <= cur_full;
        bci   <= cur_bci;
        tci   <= cur_tci;
      end
    end
  end

endmodule

// ----- rtl/cme_back.sv -----
// Element engine: per-mesh setup, trig, products and the output register.
module cme_back (
  input  logic                      clk,
  input  logic                      rst,
  input  cme_pkg::cfg_t             cfg,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  cme_pkg::desc_t            q_data,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [cme_pkg::OUT_W-1:0] m_tdata,
  output logic [1:0]                m_tuser,
  output logic                      m_tlast
);
  import cme_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  logic               fired;
  logic [2:0]         k;
  desc_t              desc;
  logic [SEG_W-1:0]   m_n;
  logic [30:0]        m_rb;
  logic [30:0]        m_rt;
  logic [29:0]        m_half;
  logic               dr_pos;
  logic [31:0]        astep;
  logic [30:0]        hs;
  logic [30:0]        ds;
  logic [29:0]        len;
  logic [31:0]        inv;
  logic [14:0]        normh;
  logic signed [15:0] normy;
  logic [31:0]        ph;
  logic signed [31:0] cs;
  logic signed [31:0] sn;
  logic signed [31:0] px;
  logic signed [31:0] pz;
  logic signed [31:0] pnx;
  logic signed [31:0] pnz;
  logic [15:0]        u;
  logic signed [65:0] mul_p;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [31:0]        div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;
  logic               sq_start;
  logic               sq_done;
  logic [29:0]        sq_root;
  logic               cor_start;
  logic               cor_done;
  logic signed [31:0] cor_cs;
  logic signed [31:0] cor_sn;
  logic               out_free;
  logic               needs_trig;
  logic               top_side;
  logic [30:0]        rsel;
  logic signed [31:0] dr;
  logic [46:0]        nrm_t;
  logic [14:0]        nrm_c;
  logic [30:0]        sqsum;
  logic [OUT_W-1:0]   emit_data;
  logic signed [31:0] y_val;
  logic signed [31:0] tu_ring;
  logic signed [31:0] tv_ring;

  function automatic logic signed [31:0] sr30(input logic signed [65:0] p);
    logic [65:0] mag;
    logic [65:0] m;
    mag = p[65] ? 66'(-p) : 66'(p);
    m   = (mag + 66'd536870912) >> 30;
    return p[65] ? -$signed(m[31:0]) : $signed(m[31:0]);
  endfunction

  cme_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  cme_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (DIV_W'({sqsum, 28'b0})),
    .done     (sq_done),
    .root     (sq_root)
  );

  cme_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .ph    (ph),
    .done  (cor_done),
    .cs    (cor_cs),
    .sn    (cor_sn)
  );

  assign out_free   = !m_tvalid || m_tready;
  assign needs_trig = desc.kind == KIND_VERTEX
                   && (desc.phase == PH_LAT_V || desc.phase == PH_BRING
                       || desc.phase == PH_TRING);
  assign top_side   = (desc.phase == PH_LAT_V) ? desc.ring
                   : (desc.phase == PH_TRING || desc.phase == PH_TCENTER);
  assign rsel       = top_side ? m_rt : m_rb;
  assign dr         = $signed({1'b0, cfg.rt}) - $signed({1'b0, cfg.rb});
  assign sqsum      = 31'({16'b0, hs[14:0]} * {16'b0, hs[14:0]})
                    + 31'({16'b0, ds[14:0]} * {16'b0, ds[14:0]});
  assign nrm_t      = 47'((mul_p + 66'sd1073741824) >>> 31);
  assign nrm_c      = (nrm_t > 47'd16384) ? 15'd16384 : nrm_t[14:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:      if (q_valid) state_next = q_data.setup ? B_ASTEP : B_DISPATCH;
      B_ASTEP:     if (div_done) state_next = (hs == '0 && ds == '0) ? B_DISPATCH
                                                                     : B_NSCALE_DN;
      B_NSCALE_DN: if (!(hs >= 31'd32768 || ds >= 31'd32768)) state_next = B_NSCALE_UP;
      B_NSCALE_UP: if (!(hs < 31'd16384 && ds < 31'd16384)) state_next = B_SQRT;
      B_SQRT:      if (sq_done) state_next = B_NDIV;
      B_NDIV:      if (div_done) state_next = B_NMUL;
      B_NMUL:      if (k == 3'd2) state_next = B_DISPATCH;
      B_DISPATCH:  state_next = needs_trig ? B_PHASE : B_EMIT;
      B_PHASE:     state_next = B_CORDIC;
      B_CORDIC:    if (cor_done) state_next = B_PROD;
      B_PROD:      if (k == 3'd4) state_next = (desc.phase == PH_LAT_V) ? B_UDIV : B_EMIT;
      B_UDIV:      if (div_done) state_next = B_EMIT;
      B_EMIT:      if (out_free) state_next = B_IDLE;
      default:     state_next = B_IDLE;
    endcase
  end

  // unit controls and multiplier operands
  always_comb begin
    q_ready      = state == B_IDLE;
    div_start    = !fired && (state == B_ASTEP || state == B_NDIV || state == B_UDIV);
    sq_start     = !fired && state == B_SQRT;
    cor_start    = !fired && state == B_CORDIC;
    div_dividend = '0;
    div_divisor  = {21'b0, m_n};
    mul_a        = '0;
    mul_b        = '0;
    unique case (state)
      B_ASTEP: div_dividend = DIV_W'(33'h1_0000_0000) + DIV_W'(m_n >> 1);
      B_NDIV: begin
        div_dividend = DIV_W'(60'd1 << 59);
        div_divisor  = {2'b0, len};
      end
      B_UDIV: div_dividend = DIV_W'({(m_n - desc.seg), 15'b0}) + DIV_W'(m_n >> 1);
      B_NMUL: begin
        mul_a = $signed({1'b0, inv});
        mul_b = (k == 3'd0) ? $signed({18'b0, hs[14:0]}) : $signed({18'b0, ds[14:0]});
      end
      B_PROD: begin
        mul_a = (k < 3'd2) ? $signed({2'b0, rsel})
              : ((desc.phase == PH_LAT_V) ? $signed({18'b0, normh}) : 33'sd16384);
        mul_b = (k == 3'd0 || k == 3'd2) ? 33'(cs) : 33'(sn);
      end
      default: ;
    endcase
  end

  // result fields of the element in hand
  always_comb begin
    y_val     = top_side ? $signed({2'b0, m_half}) : -$signed({2'b0, m_half});
    tu_ring   = 32'sd16384 + pnx;
    tv_ring   = 32'sd16384 + pnz;
    emit_data = '0;
    case (desc.kind)
      KIND_VERTEX: begin
        emit_data[63:32] = y_val;
        case (desc.phase)
          PH_LAT_V: begin
            emit_data[31:0]    = px;
            emit_data[95:64]   = pz;
            emit_data[111:96]  = pnx[15:0];
            emit_data[127:112] = normy;
            emit_data[143:128] = pnz[15:0];
            emit_data[159:144] = u;
            emit_data[175:160] = desc.ring ? 16'd32768 : 16'd0;
          end
          PH_BRING, PH_TRING: begin
            emit_data[31:0]    = px;
            emit_data[95:64]   = pz;
            emit_data[127:112] = top_side ? 16'sd16384 : -16'sd16384;
            emit_data[159:144] = tu_ring[15:0];
            emit_data[175:160] = tv_ring[15:0];
          end
          default: begin
            emit_data[127:112] = top_side ? 16'sd16384 : -16'sd16384;
            emit_data[159:144] = 16'd16384;
            emit_data[175:160] = 16'd16384;
          end
        endcase
      end
      KIND_TRI: begin
        emit_data[31:0]  = {19'b0, desc.a};
        emit_data[63:32] = {19'b0, desc.b};
        emit_data[95:64] = {19'b0, desc.c};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    k     <= (state_next == state) ? k + 3'd1 : 3'd0;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          desc <= q_data;
          if (q_data.setup) begin
            m_n    <= cfg.n;
            m_rb   <= cfg.rb;
            m_rt   <= cfg.rt;
            m_half <= cfg.h[30:1];
            hs     <= cfg.h;
            ds     <= dr[31] ? 31'(-dr) : dr[30:0];
            dr_pos <= dr > 0;
          end
        end
      end
      B_ASTEP: begin
        if (div_done) begin
          astep <= div_q[31:0];
          normh <= 15'd16384;
          normy <= '0;
        end
      end
      B_NSCALE_DN: begin
        if (hs >= 31'd32768 || ds >= 31'd32768) begin
          hs <= hs >> 1;
          ds <= ds >> 1;
        end
      end
      B_NSCALE_UP: begin
        if (hs < 31'd16384 && ds < 31'd16384) begin
          hs <= hs << 1;
          ds <= ds << 1;
        end
      end
      B_SQRT: if (sq_done) len <= sq_root;
      B_NDIV: if (div_done) inv <= div_q[31:0];
      B_NMUL: begin
        if (k == 3'd1) normh <= nrm_c;
        if (k == 3'd2) normy <= dr_pos ? -$signed({1'b0, nrm_c}) : $signed({1'b0, nrm_c});
      end
      B_PHASE: ph <= (desc.seg >= m_n) ? 32'd0 : 32'(desc.seg * astep);
      B_CORDIC: begin
        if (cor_done) begin
          cs <= cor_cs;
          sn <= cor_sn;
        end
      end
      B_PROD: begin
        case (k)
          3'd1:    px  <= sr30(mul_p);
          3'd2:    pz  <= sr30(mul_p);
          3'd3:    pnx <= sr30(mul_p);
          3'd4:    pnz <= sr30(mul_p);
          default: ;
        endcase
      end
      B_UDIV: if (div_done) u <= div_q[15:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == B_EMIT && out_free) begin
      m_tdata <= emit_data;
      m_tuser <= desc.kind;
      m_tlast <= desc.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      fired    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      fired <= (state_next == state) ? (fired | div_start | sq_start | cor_start) : 1'b0;
      if (state == B_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/cme_checker.sv -----
// Port-level checks of the mesh emitter, bound to the top level.
module cme_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [cme_pkg::OUT_W-1:0] m_tdata,
  input logic [1:0]                m_tuser,
  input logic                      m_tlast
);
  import cme_pkg::*;

  // hold a stalled beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled output beat changed");

  a_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ERROR |-> m_tlast && m_tdata == '0)
    else $error("error beat not last or not zero");

  a_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_DONE |-> !m_tlast && m_tdata == '0)
    else $error("done beat malformed");

  a_attr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_VERTEX |-> m_tdata[OUT_W-1:96] == '0)
    else $error("non-vertex beat carries normal or texture");

endmodule

bind cylinder_mesh_emitter cme_checker u_cme_checker (.*);

// ----- sim/tb_cylinder_mesh_emitter.sv -----
// Self-checking testbench of the cylinder and cone mesh emitter.
module tb_cylinder_mesh_emitter;
  timeunit 1ns;
  timeprecision 1ps;
  import cme_pkg::*;

  localparam int  ITEM_GOAL   = 700;
  localparam int  SETTLE      = 400;
  localparam longint LIMIT    = 3000000;
  localparam longint ONE_Q30  = 64'sd1073741824;
  localparam longint CORDIC_K = 64'sd652032874;

  localparam longint ATAN_TAB [28] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
    163, 81, 41, 20, 10, 5};

  typedef struct packed {
    kind_t       kind;
    logic [31:0] x, y, z;
    logic [15:0] nx, ny, nz, u, v;
    logic        last;
  } elem_t;

  typedef enum int {OP_CFG, OP_ITEM, OP_MESH, OP_RUN} op_t;

  typedef struct {
    op_t         op;
    reg_idx_t    idx;
    logic [31:0] data;
    logic        restart;
    int          count;
    logic        typed;
    kind_t       kind;
    logic        last;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic [7:0] s_tdata = '0;
  logic m_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tready, m_tvalid, m_tlast, cfg_ready;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0] m_tuser;

  cylinder_mesh_emitter u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // register copies and mesh state of the predictor
  logic [30:0] rb_reg = 31'd65536, rt_reg = 31'd65536, h_reg = 31'd65536;
  logic [10:0] n_reg = 11'd16;
  logic        cb_reg = 1'b1, ct_reg = 1'b1;
  phase_t      mph = PH_IDLE;
  int unsigned seg = 0, ring = 0, bci = 0, tci = 0, astep = 0, n_lat = 0;
  longint      lrb = 0, lrt = 0, lhalf = 0, normh = 0, normy = 0;
  bit          bcap = 0, tcap = 0;

  elem_t mesh_q[$];
  int    errors = 0;
  int    items_sent = 0;
  int    s_idle_pct = 0, r_idle_pct = 0;
  longint cycles = 0;

  function automatic longint round_mul(longint a, longint c);
    longint p, m;
    p = a * c;
    m = p < 0 ? -p : p;
    m = (m + (64'sd1 << 29)) >>> 30;
    return p < 0 ? -m : m;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic sin_cos(input logic [31:0] ph, output longint cs, output longint sn);
    longint x, y, z, dx, dy;
    x = CORDIC_K;
    y = 0;
    z = longint'(ph[29:0]);
    for (int i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    if (x > ONE_Q30) x = ONE_Q30;
    if (x < -ONE_Q30) x = -ONE_Q30;
    if (y > ONE_Q30) y = ONE_Q30;
    if (y < -ONE_Q30) y = -ONE_Q30;
    case (ph[31:30])
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endtask

  task automatic column_angle(input int unsigned s, output longint cs, output longint sn);
    logic [31:0] ph;
    ph = (s >= n_lat) ? 32'd0 : 32'(s * astep);
    sin_cos(ph, cs, sn);
  endtask

  task automatic prepare_normal();
    longint dr;
    longint unsigned hs, ds, len, hn, dn, inv;
    dr = lrt - lrb;
    hs = h_reg;
    ds = dr < 0 ? -dr : dr;
    if (hs == 0 && ds == 0) begin
      normh = 16384;
      normy = 0;
      return;
    end
    while (hs >= 32768 || ds >= 32768) begin hs >>= 1; ds >>= 1; end
    while (hs < 16384 && ds < 16384) begin hs <<= 1; ds <<= 1; end
    len = int_sqrt((hs * hs + ds * ds) << 28);
    inv = 64'(32'((64'd1 << 59) / len));
    hn = (hs * inv + (64'd1 << 30)) >> 31;
    dn = (ds * inv + (64'd1 << 30)) >> 31;
    if (hn > 16384) hn = 16384;
    if (dn > 16384) dn = 16384;
    normh = hn;
    normy = dr > 0 ? -longint'(dn) : longint'(dn);
  endtask

  function automatic void open_phase(int p);
    for (; p <= int'(PH_TTRI); p++) begin
      if ((p == PH_BCENTER || p == PH_BRING || p == PH_BTRI) && !bcap) continue;
      if ((p == PH_TCENTER || p == PH_TRING || p == PH_TTRI) && !tcap) continue;
      mph = phase_t'(p);
      seg = 0;
      ring = 0;
      return;
    end
    mph = PH_IDLE;
    seg = 0;
    ring = 0;
  endfunction

  function automatic void step_phase();
    case (mph)
      PH_LAT_V:
        if (seg < n_lat) seg++;
        else if (ring == 0) begin ring = 1; seg = 0; end
        else open_phase(PH_BCENTER);
      PH_BCENTER, PH_TCENTER: open_phase(int'(mph) + 1);
      PH_BRING, PH_TRING:
        if (seg < n_lat) seg++;
        else open_phase(int'(mph) + 1);
      PH_LAT_T: begin
        if (lrb > 0 && lrt > 0 && ring == 0) begin
          ring = 1;
        end else begin
          ring = 0;
          if (seg + 1 < n_lat) seg++;
          else open_phase(PH_BTRI);
        end
      end
      PH_BTRI, PH_TTRI:
        if (seg + 1 < n_lat) seg++;
        else open_phase(int'(mph) + 1);
      default: mph = PH_IDLE;
    endcase
  endfunction

  // next mesh element for one input beat
  task automatic mesh_next(input logic restart, output elem_t e);
    longint v[10];
    longint cs, sn, r;
    int unsigned s, rw;
    foreach (v[i]) v[i] = 0;
    cs = 0; sn = 0;
    if (restart) begin
      if (n_reg < 3 || n_reg > MAX_SEGMENTS) begin
        mph = PH_IDLE; seg = 0; ring = 0;
        e = '{kind: KIND_ERROR, last: 1'b1, default: '0};
        return;
      end
      n_lat = n_reg;
      lrb = rb_reg;
      lrt = rt_reg;
      lhalf = h_reg >> 1;
      bcap = cb_reg && lrb > 0;
      tcap = ct_reg && lrt > 0;
      astep = 32'(((64'd1 << 32) + n_lat / 2) / n_lat);
      bci = 2 * (n_lat + 1);
      tci = bci + (bcap ? n_lat + 2 : 0);
      prepare_normal();
      mph = PH_LAT_V; seg = 0; ring = 0;
    end
    s = seg;
    rw = n_lat + 1;
    case (mph)
      PH_LAT_V: begin
        r = ring ? lrt : lrb;
        column_angle(s, cs, sn);
        v[1] = round_mul(r, cs);
        v[2] = ring ? lhalf : -lhalf;
        v[3] = round_mul(r, sn);
        v[4] = round_mul(normh, cs);
        v[5] = normy;
        v[6] = round_mul(normh, sn);
        v[7] = ((n_lat - s) * 64'd32768 + n_lat / 2) / n_lat;
        v[8] = ring ? 32768 : 0;
      end
      PH_BCENTER, PH_TCENTER: begin
        v[2] = mph == PH_TCENTER ? lhalf : -lhalf;
        v[5] = mph == PH_TCENTER ? 16384 : -16384;
        v[7] = 16384; v[8] = 16384;
      end
      PH_BRING, PH_TRING: begin
        r = mph == PH_TRING ? lrt : lrb;
        column_angle(s, cs, sn);
        v[1] = round_mul(r, cs);
        v[2] = mph == PH_TRING ? lhalf : -lhalf;
        v[3] = round_mul(r, sn);
        v[5] = mph == PH_TRING ? 16384 : -16384;
        v[7] = 16384 + round_mul(16384, cs);
        v[8] = 16384 + round_mul(16384, sn);
      end
      PH_LAT_T: begin
        v[0] = KIND_TRI;
        if (lrb > 0 && lrt > 0) begin
          if (ring == 0) begin v[1] = s; v[2] = s + 1; v[3] = rw + s; end
          else begin v[1] = s + 1; v[2] = rw + s + 1; v[3] = rw + s; end
        end else if (lrb > 0) begin
          v[1] = s; v[2] = s + 1; v[3] = rw + s;
        end else begin
          v[1] = s; v[2] = rw + s; v[3] = rw + s + 1;
        end
      end
      PH_BTRI: begin
        v[0] = KIND_TRI;
        v[1] = bci; v[2] = bci + 2 + s; v[3] = bci + 1 + s;
      end
      PH_TTRI: begin
        v[0] = KIND_TRI;
        v[1] = tci; v[2] = tci + 1 + s; v[3] = tci + 2 + s;
      end
      default: begin
        e = '{kind: KIND_DONE, last: 1'b0, default: '0};
        return;
      end
    endcase
    step_phase();
    e.kind = kind_t'(v[0][1:0]);
    e.x = v[1][31:0]; e.y = v[2][31:0]; e.z = v[3][31:0];
    e.nx = v[4][15:0]; e.ny = v[5][15:0]; e.nz = v[6][15:0];
    e.u = v[7][15:0]; e.v = v[8][15:0];
    e.last = mph == PH_IDLE;
  endtask

  function automatic void apply_reg(reg_idx_t idx, logic [31:0] d);
    case (idx)
      REG_RB: rb_reg = d[30:0];
      REG_RT: rt_reg = d[30:0];
      REG_H:  h_reg = d[30:0];
      REG_N:  n_reg = d[10:0];
      REG_CB: cb_reg = d[0];
      REG_CT: ct_reg = d[0];
      default: ;
    endcase
  endfunction

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(reg_idx_t idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, d);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // leaves s_tvalid high; a gap drops it in a step of its own
  task automatic send_beat(input logic restart, input logic typed, input elem_t typed_e,
                           output logic last);
    elem_t e;
    while ($urandom_range(99) < s_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'($urandom_range(127)), restart};
    do @(posedge clk); while (!s_tready);
    mesh_next(restart, e);
    last = e.last;
    mesh_q.insert(mesh_q.size(), typed ? typed_e : e);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (mesh_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_mesh(input int max_beats);
    logic last;
    elem_t dummy;
    dummy = '{kind: KIND_DONE, default: '0};
    send_beat(1'b1, 1'b0, dummy, last);
    for (int k = 1; k < max_beats && !last; k++) send_beat(1'b0, 1'b0, dummy, last);
  endtask

  // check output beats, then pick the next ready
  always @(posedge clk) begin
    elem_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = kind_t'(m_tuser);
      got.x = m_tdata[31:0];     got.y = m_tdata[63:32];   got.z = m_tdata[95:64];
      got.nx = m_tdata[111:96];  got.ny = m_tdata[127:112]; got.nz = m_tdata[143:128];
      got.u = m_tdata[159:144];  got.v = m_tdata[175:160];
      got.last = m_tlast;
      if (mesh_q.size() == 0) begin
        if (errors < 10) $display("unexpected beat kind=%0d", got.kind);
        errors++;
      end else begin
        want = mesh_q.pop_front();
        if (got != want) begin
          if (errors < 10) begin
            $display("mismatch: exp k%0d %h %h %h n %h %h %h t %h %h l%b",
                     want.kind, want.x, want.y, want.z, want.nx, want.ny, want.nz,
                     want.u, want.v, want.last);
            $display("          act k%0d %h %h %h n %h %h %h t %h %h l%b",
                     got.kind, got.x, got.y, got.z, got.nx, got.ny, got.nz,
                     got.u, got.v, got.last);
          end
          errors++;
        end
      end
    end
    m_tready <= !($urandom_range(99) < r_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_len();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(32'h0008_0000, 1);
    endcase
  endfunction

  function automatic logic [31:0] pick_count();
    int c;
    c = $urandom_range(99);
    if (c < 8) return $urandom_range(2);
    if (c < 13) return $urandom_range(2047, 1025);
    if (c < 16) return MAX_SEGMENTS;
    return $urandom_range(9, 3);
  endfunction

  function automatic void pick_pressure();
    case ($urandom_range(3))
      0: begin s_idle_pct = 0;  r_idle_pct = 0;  end
      1: begin s_idle_pct = 56; r_idle_pct = 0;  end
      2: begin s_idle_pct = 0;  r_idle_pct = 56; end
      default: begin s_idle_pct = 14; r_idle_pct = 14; end
    endcase
  endfunction

  row_t plan[] = '{
    '{OP_ITEM, REG_RB, 0, 1'b0, 1, 1'b1, KIND_DONE, 1'b0},
    '{OP_CFG, REG_N, 2, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_ITEM, REG_RB, 0, 1'b1, 1, 1'b1, KIND_ERROR, 1'b1},
    '{OP_ITEM, REG_RB, 0, 1'b0, 1, 1'b1, KIND_DONE, 1'b0},
    '{OP_CFG, REG_N, 0, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_ITEM, REG_RB, 0, 1'b1, 1, 1'b1, KIND_ERROR, 1'b1},
    '{OP_CFG, REG_N, 2047, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_ITEM, REG_RB, 0, 1'b1, 1, 1'b1, KIND_ERROR, 1'b1},
    '{OP_CFG, REG_N, 1025, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_ITEM, REG_RB, 0, 1'b1, 1, 1'b1, KIND_ERROR, 1'b1},
    // cone with its tip at the bottom, flat
    '{OP_CFG, REG_N, 3, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_CFG, REG_RB, 0, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_CFG, REG_RT, 32'h7FFF_FFFF, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_CFG, REG_H, 0, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_MESH, REG_RB, 0, 1'b1, 100, 1'b0, KIND_DONE, 1'b0},
    '{OP_ITEM, REG_RB, 0, 1'b0, 1, 1'b1, KIND_DONE, 1'b0},
    // cone with its tip at the top, bottom cap off
    '{OP_CFG, REG_RB, 32'h7FFF_FFFF, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_CFG, REG_RT, 0, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_CFG, REG_H, 32'h7FFF_FFFF, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_CFG, REG_CB, 0, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_MESH, REG_RB, 0, 1'b1, 100, 1'b0, KIND_DONE, 1'b0},
    // cylinder: equal radii at the largest height, top cap off
    '{OP_CFG, REG_RB, 65536, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_CFG, REG_RT, 65536, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_CFG, REG_CB, 1, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_CFG, REG_CT, 0, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_CFG, REG_N, 4, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_MESH, REG_RB, 0, 1'b1, 100, 1'b0, KIND_DONE, 1'b0},
    // largest segment count, cut short by a second restart
    '{OP_CFG, REG_N, MAX_SEGMENTS, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_CFG, REG_CT, 1, 1'b0, 0, 1'b0, KIND_DONE, 1'b0},
    '{OP_RUN, REG_RB, 0, 1'b1, 4, 1'b0, KIND_DONE, 1'b0},
    '{OP_RUN, REG_RB, 0, 1'b1, 3, 1'b0, KIND_DONE, 1'b0}
  };

  initial begin
    logic last;
    elem_t typed_e;
    int pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      case (plan[i].op)
        OP_CFG: begin
          drain();
          write_reg(plan[i].idx, plan[i].data);
          end_writes();
        end
        OP_ITEM: begin
          typed_e = '{kind: plan[i].kind, last: plan[i].last, default: '0};
          send_beat(plan[i].restart, plan[i].typed, typed_e, last);
        end
        default: run_mesh(plan[i].count);
      endcase
    end

    while (items_sent < ITEM_GOAL) begin
      drain();
      pick_pressure();
      write_reg(REG_RB, pick_len());
      write_reg(REG_RT, pick_len());
      write_reg(REG_H, pick_len());
      write_reg(REG_N, pick_count());
      write_reg(REG_CB, $urandom_range(1));
      write_reg(REG_CT, $urandom_range(1));
      end_writes();
      pick = $urandom_range(9);
      typed_e = '{kind: KIND_DONE, default: '0};
      if (n_reg == MAX_SEGMENTS || pick < 2) begin
        // broken sequence: stray advances and a restart partway
        for (int k = $urandom_range(3); k > 0; k--) send_beat(1'b0, 1'b0, typed_e, last);
        run_mesh($urandom_range(8, 1));
        run_mesh(n_reg == MAX_SEGMENTS ? 6 : 400);
      end else begin
        run_mesh(400);
      end
      for (int k = $urandom_range(2); k > 0; k--) send_beat(1'b0, 1'b0, typed_e, last);
    end

    drain();
    if (errors == 0 && mesh_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cme_pkg.sv
rtl/cme_fifo.sv
rtl/cme_div.sv
rtl/cme_sqrt.sv
rtl/cme_cordic.sv
rtl/cme_front.sv
rtl/cme_back.sv
rtl/cylinder_mesh_emitter.sv
rtl/cme_checker.sv
sim/tb_cylinder_mesh_emitter.sv
